// ===== hdl/wme_pkg.sv =====
package wme_pkg;

  // Number of display columns in one frame.
  localparam int unsigned COLUMNS = 160;

  localparam int unsigned COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SPF_W      = 16;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned OUT_COL_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // (column + 1) * frame length stays below 256 * 65536.
  localparam int unsigned PROD_W = 24;

  // Reciprocal of COLUMNS scaled by 2^32, rounded up. The product with any
  // PROD_W-bit dividend, shifted right by 32, is the exact floor quotient.
  localparam int unsigned DIV_SHIFT = 32;
  localparam logic [31:0] DIV_RECIP =
    32'(((64'd1 << DIV_SHIFT) + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS));
  localparam int unsigned DIV_PROD_W = PROD_W + 32;

  localparam logic [SPF_W-1:0] SPF_RESET    = 16'd1024;
  localparam logic [ROW_W-1:0] TOP_RESET    = 8'd1;
  localparam logic [ROW_W-1:0] BOTTOM_RESET = 8'd62;
  localparam logic [SPF_W-1:0] MIN_FRAME    = SPF_W'(COLUMNS);
  localparam logic [COL_W-1:0] LAST_COL     = COL_W'(COLUMNS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPF    = 2'd0,
    REG_TOP    = 2'd1,
    REG_BOTTOM = 2'd2
  } wme_reg_e;

  typedef struct packed {
    logic [SPF_W-1:0] frame_len;
    logic [ROW_W-1:0] top_row;
    logic [ROW_W-1:0] bottom_row;
    logic             len_wr;
    logic [SPF_W-1:0] len_new;
  } wme_cfg_t;

  typedef struct packed {
    logic                       close;
    logic                       last;
    logic [COL_W-1:0]           col;
    logic signed [SAMPLE_W-1:0] max_val;
    logic signed [SAMPLE_W-1:0] min_val;
  } wme_res_t;

  // Floor of x / COLUMNS through the scaled reciprocal.
  function automatic logic [SPF_W-1:0] div_cols(input logic [PROD_W-1:0] x);
    logic [DIV_PROD_W-1:0] prod;
    prod = DIV_PROD_W'(x) * DIV_PROD_W'(DIV_RECIP);
    return prod[DIV_SHIFT +: SPF_W];
  endfunction

endpackage

// ===== hdl/wme_if.sv =====
interface wme_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wme_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface wme_env_if;
  logic                            valid;
  logic                            ready;
  logic [wme_pkg::OUT_COL_W-1:0]   column;
  logic [wme_pkg::ROW_W-1:0]       peak_row;
  logic [wme_pkg::ROW_W-1:0]       trough_row;
  logic                            frame_end;

  modport source (output valid, output column, output peak_row, output trough_row,
                  output frame_end, input ready);
  modport sink (input valid, input column, input peak_row, input trough_row,
                input frame_end, output ready);
endinterface

// ===== hdl/wme_cfg_regs.sv =====
module wme_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wme_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wme_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output wme_pkg::wme_cfg_t                cfg_o
);

  logic [wme_pkg::SPF_W-1:0] len_q, len_new;
  logic [wme_pkg::ROW_W-1:0] top_q, bottom_q;
  logic                      len_wr;

  // Frame lengths below the column count are stored as the column count.
  assign len_new = (cfg_wdata_i < wme_pkg::MIN_FRAME) ? wme_pkg::MIN_FRAME : cfg_wdata_i;
  assign len_wr  = cfg_we_i && (cfg_idx_i == wme_pkg::REG_SPF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= wme_pkg::SPF_RESET;
      top_q    <= wme_pkg::TOP_RESET;
      bottom_q <= wme_pkg::BOTTOM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wme_pkg::REG_SPF:    len_q    <= len_new;
        wme_pkg::REG_TOP:    top_q    <= cfg_wdata_i[wme_pkg::ROW_W-1:0];
        wme_pkg::REG_BOTTOM: bottom_q <= cfg_wdata_i[wme_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.frame_len  = len_q;
  assign cfg_o.top_row    = top_q;
  assign cfg_o.bottom_row = bottom_q;
  assign cfg_o.len_wr     = len_wr;
  assign cfg_o.len_new    = len_new;

endmodule

// ===== hdl/wme_envelope.sv =====
module wme_envelope (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic signed [wme_pkg::SAMPLE_W-1:0] sample_i,
  input  wme_pkg::wme_cfg_t                   cfg_i,
  output wme_pkg::wme_res_t                   res_o
);

  logic [wme_pkg::SPF_W-1:0]   pos_q, bnd_q;
  logic [wme_pkg::COL_W-1:0]   col_q;
  logic [wme_pkg::PROD_W-1:0]  prod_q;
  logic                        open_q;
  logic signed [wme_pkg::SAMPLE_W-1:0] min_q, max_q;

  logic                        start, close, last;
  logic [wme_pkg::COL_W-1:0]   col_eff;
  logic [wme_pkg::SPF_W-1:0]   bnd_eff, next_bnd, pos_inc;
  logic [wme_pkg::PROD_W-1:0]  prod_eff, prod_len, prod_cfg;
  logic [wme_pkg::COL_W:0]     col_p2;
  logic signed [wme_pkg::SAMPLE_W-1:0] min_new, max_new;

  // At a frame start the first column and its boundary are taken fresh.
  // prod_q holds (column + 2) * length, the numerator of the next boundary.
  assign start    = (pos_q == '0);
  assign col_eff  = start ? '0 : col_q;
  assign bnd_eff  = start ? wme_pkg::div_cols(wme_pkg::PROD_W'(cfg_i.frame_len)) : bnd_q;
  assign prod_eff = start ? wme_pkg::PROD_W'({cfg_i.frame_len, 1'b0}) : prod_q;
  assign next_bnd = wme_pkg::div_cols(prod_eff);
  assign prod_len = prod_eff + wme_pkg::PROD_W'(cfg_i.frame_len);

  assign pos_inc  = pos_q + 1'b1;
  assign close    = (pos_inc >= bnd_eff);
  assign last     = (col_eff == wme_pkg::LAST_COL);

  assign min_new  = (!open_q || (sample_i < min_q)) ? sample_i : min_q;
  assign max_new  = (!open_q || (sample_i > max_q)) ? sample_i : max_q;

  // A new frame length reloads the next-boundary numerator for the open column.
  assign col_p2   = (wme_pkg::COL_W + 1)'(col_q) + (wme_pkg::COL_W + 1)'(2);
  assign prod_cfg = wme_pkg::PROD_W'(col_p2) * wme_pkg::PROD_W'(cfg_i.len_new);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      col_q  <= '0;
      bnd_q  <= '0;
      prod_q <= '0;
      open_q <= 1'b0;
    end else if (adv_i) begin
      open_q <= !close;
      if (close && last) begin
        pos_q <= '0;
        col_q <= '0;
      end else if (close) begin
        pos_q  <= pos_inc;
        col_q  <= col_eff + 1'b1;
        bnd_q  <= next_bnd;
        prod_q <= prod_len;
      end else begin
        pos_q  <= pos_inc;
        col_q  <= col_eff;
        bnd_q  <= bnd_eff;
        prod_q <= prod_eff;
      end
    end else if (cfg_i.len_wr) begin
      prod_q <= prod_cfg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      min_q <= min_new;
      max_q <= max_new;
    end
  end

  assign res_o.close   = close;
  assign res_o.last    = last;
  assign res_o.col     = col_eff;
  assign res_o.max_val = max_new;
  assign res_o.min_val = min_new;

endmodule

// ===== hdl/wme_row_map.sv =====
module wme_row_map (
  input  logic signed [wme_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [wme_pkg::ROW_W-1:0]           top_i,
  input  logic [wme_pkg::ROW_W-1:0]           bottom_i,
  output logic [wme_pkg::ROW_W-1:0]           row_o
);

  logic signed [9:0]  top_s, bottom_s, diff, half, center, quot, y;
  logic        [8:0]  sum;
  logic signed [25:0] prod, prod_adj, prod_sh;

  assign top_s    = $signed({2'b00, top_i});
  assign bottom_s = $signed({2'b00, bottom_i});
  assign diff     = bottom_s - top_s;
  // Halving truncates toward zero, also for inverted rows.
  assign half     = diff[9] ? ((diff + 10'sd1) >>> 1) : (diff >>> 1);
  assign sum      = {1'b0, top_i} + {1'b0, bottom_i};
  assign center   = $signed({2'b00, sum[8:1]});

  assign prod     = 26'(sample_i) * 26'(half);
  assign prod_adj = prod[25] ? (prod + 26'sd32767) : prod;
  assign prod_sh  = prod_adj >>> 15;
  assign quot     = prod_sh[9:0];
  assign y        = center - quot;

  always_comb begin
    if (y < top_s) begin
      row_o = top_i;
    end else if (y > bottom_s) begin
      row_o = bottom_i;
    end else begin
      row_o = y[wme_pkg::ROW_W-1:0];
    end
  end

endmodule

// ===== hdl/waveform_minmax_envelope_unit.sv =====
// Channel   Dir  Beat payload                                  Accepted when
// in_i      in   sample (s16)                                  in_i.valid && in_i.ready
// out_o     out  column, peak_row, trough_row, frame_end       out_o.valid && out_o.ready
// cfg       in   cfg_idx_i, cfg_wdata_i                        cfg_we_i
//
// One sample beat is taken every cycle while out_o keeps up. A beat sits in the
// input register until it may advance; it then passes the envelope logic, and a
// sample that closes a column loads the result register, which raises out_o.valid.
// The rate is set by the single envelope stage, which also holds the frame
// position, the open column's precomputed boundary and the next one's numerator.
// Reset clears positions and valid flags; the first sample then starts a frame.
// While a result waits on out_o the input register fills and in_i.ready drops.
module waveform_minmax_envelope_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  wme_sample_if.sink                       in_i,
  wme_env_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [wme_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wme_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  wme_pkg::wme_cfg_t cfg;
  wme_pkg::wme_res_t res;

  logic                                s_valid_q;
  logic signed [wme_pkg::SAMPLE_W-1:0] s_sample_q;
  logic                                o_valid_q;
  logic [wme_pkg::OUT_COL_W-1:0]       o_col_q;
  logic [wme_pkg::ROW_W-1:0]           o_peak_q, o_trough_q;
  logic                                o_last_q;
  logic [wme_pkg::ROW_W-1:0]           peak_row, trough_row;
  logic                                adv, in_ready;

  // The staged sample moves on when the result register is free or drains now,
  // whether or not this sample closes a column.
  assign adv      = s_valid_q && (!o_valid_q || out_o.ready);
  assign in_ready = !s_valid_q || adv;
  assign in_i.ready = in_ready;

  wme_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  wme_envelope u_env (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .sample_i (s_sample_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // The maximum sample maps to the peak row and the minimum to the trough row.
  wme_row_map u_peak (
    .sample_i (res.max_val),
    .top_i    (cfg.top_row),
    .bottom_i (cfg.bottom_row),
    .row_o    (peak_row)
  );

  wme_row_map u_trough (
    .sample_i (res.min_val),
    .top_i    (cfg.top_row),
    .bottom_i (cfg.bottom_row),
    .row_o    (trough_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s_valid_q <= in_i.valid;
      end
      if (adv && res.close) begin
        o_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      s_sample_q <= in_i.sample;
    end
    if (adv && res.close) begin
      o_col_q    <= wme_pkg::OUT_COL_W'(res.col);
      o_peak_q   <= peak_row;
      o_trough_q <= trough_row;
      o_last_q   <= res.last;
    end
  end

  assign out_o.valid      = o_valid_q;
  assign out_o.column     = o_col_q;
  assign out_o.peak_row   = o_peak_q;
  assign out_o.trough_row = o_trough_q;
  assign out_o.frame_end  = o_last_q;

`ifndef SYNTHESIS
  // The last column of a frame is always the top column index.
  a_frame_end_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.frame_end) |->
      (out_o.column == wme_pkg::OUT_COL_W'(wme_pkg::COLUMNS - 1)))
    else $error("frame end flagged on a column other than the last");

  // Backpressure on the input only comes from a held sample behind a full,
  // stalled result register.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s_valid_q && o_valid_q && !out_o.ready))
    else $error("input stalled without a blocked result");

  // A result beat only appears when a staged sample advanced.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(o_valid_q) |-> $past(adv))
    else $error("result beat appeared without an advancing sample");

  // A stalled result keeps the staged sample in place.
  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && !out_o.ready && s_valid_q) |=> (s_valid_q && $stable(s_sample_q)))
    else $error("staged sample lost while the result was stalled");
`endif

endmodule

// ===== sim/waveform_minmax_envelope_unit_tb.sv =====
`timescale 1ns / 100ps

module waveform_minmax_envelope_unit_tb;

  // One completed column as it leaves the block.
  typedef struct packed {
    logic [wme_pkg::OUT_COL_W-1:0] column;
    logic [wme_pkg::ROW_W-1:0]     peak;
    logic [wme_pkg::ROW_W-1:0]     trough;
    logic                          frame_end;
  } col_env_t;

  // A row of the directed script is either a sample beat or a register write.
  typedef enum logic [0:0] {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    wme_pkg::wme_reg_e reg_sel;
    logic [15:0]       value;
    logic              typed;
    col_env_t          want;
  } script_row_t;

  // One random phase: register settings, beat count and idle percentages.
  typedef struct packed {
    logic [wme_pkg::SPF_W-1:0] spf;
    logic [wme_pkg::ROW_W-1:0] top;
    logic [wme_pkg::ROW_W-1:0] bottom;
    int unsigned               beats;
    int unsigned               send_pct;
    int unsigned               recv_pct;
  } phase_t;

  localparam col_env_t NO_ENV = '0;

  // The directed script starts from the reset settings (frame of 1024, rows 1 to 62),
  // so column 0 closes after six samples. Expected beats are typed in only where they
  // follow directly from full-scale samples; everything else goes to the predictor.
  localparam int unsigned SCRIPT_LEN = 29;
  localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h7FFF, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h8000, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h0000, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h0001, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'hFFFF, 1'b0, NO_ENV},
    // Column 0 closes: full-scale max maps to row 2, full-scale min to row 61.
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'd100,  1'b1, '{8'd0, 8'd2, 8'd61, 1'b0}},
    // Widest possible row span.
    '{ROW_WRITE,  wme_pkg::REG_TOP,    16'd0,    1'b0, NO_ENV},
    '{ROW_WRITE,  wme_pkg::REG_BOTTOM, 16'd255,  1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h7FFF, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h7FFF, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h7FFF, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h7FFF, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h7FFF, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h7FFF, 1'b1, '{8'd1, 8'd1, 8'd1, 1'b0}},
    // Zero frame length is a short frame. Column 2 keeps its boundary at 19,
    // which was loaded under the old length.
    '{ROW_WRITE,  wme_pkg::REG_SPF,    16'd0,    1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h8000, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h8000, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h8000, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h8000, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h8000, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h8000, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h8000, 1'b1, '{8'd2, 8'd254, 8'd254, 1'b0}},
    // Inverted rows. Later boundaries are already behind the position, so every
    // further sample closes a column at once.
    '{ROW_WRITE,  wme_pkg::REG_TOP,    16'd200,  1'b0, NO_ENV},
    '{ROW_WRITE,  wme_pkg::REG_BOTTOM, 16'd10,   1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'd12345, 1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'hFFFB, 1'b0, NO_ENV},
    // Top and bottom on the same, last row.
    '{ROW_WRITE,  wme_pkg::REG_TOP,    16'd255,  1'b0, NO_ENV},
    '{ROW_WRITE,  wme_pkg::REG_BOTTOM, 16'd255,  1'b0, NO_ENV},
    '{ROW_SAMPLE, wme_pkg::REG_SPF,    16'h8001, 1'b0, NO_ENV}
  };

  // Random phases. The first three let the sender idle lightly against a busy
  // receiver, the next three swap the two, and the last two run without gaps.
  // The first phase runs one column per sample past the end of a frame. The
  // others change the length mid-frame; where the position is already past the
  // new boundaries, columns close on consecutive samples.
  localparam int unsigned PHASE_CNT = 8;
  localparam phase_t PHASES [0:PHASE_CNT-1] = '{
    '{16'd160,   8'd1,   8'd62,  160, 20, 77},
    '{16'd1024,  8'd0,   8'd255, 40,  20, 77},
    '{16'd200,   8'd254, 8'd255, 30,  20, 77},
    '{16'd65535, 8'd10,  8'd50,  40,  77, 20},
    '{16'd159,   8'd255, 8'd0,   60,  77, 20},
    '{16'd480,   8'd30,  8'd31,  40,  77, 20},
    '{16'd2000,  8'd0,   8'd255, 30,  0,  0},
    '{16'd1,     8'd100, 8'd20,  30,  0,  0}
  };

  // Cycles to let pass after the last result before a register write, so that a
  // sample that closes no column has left the two-stage pipeline.
  localparam int unsigned HOLD_OFF    = 4;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic clk_i;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [wme_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [wme_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  wme_sample_if smp_if ();
  wme_env_if    env_if ();

  waveform_minmax_envelope_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (smp_if),
    .out_o       (env_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Column envelopes still owed by the block, oldest first.
  col_env_t pending_env [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Shadow copy of the registers and of the envelope state.
  logic [wme_pkg::SPF_W-1:0]           spf_q;
  logic [wme_pkg::ROW_W-1:0]           top_q;
  logic [wme_pkg::ROW_W-1:0]           bot_q;
  logic [15:0]                         pos_q;
  logic [7:0]                          col_q;
  logic [15:0]                         bound_q;
  logic signed [wme_pkg::SAMPLE_W-1:0] lo_q;
  logic signed [wme_pkg::SAMPLE_W-1:0] hi_q;
  bit                                  open_q;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample index at which column c ends. Frames shorter than the column count
  // are stretched to one sample per column.
  function automatic int unsigned col_end(input int unsigned c);
    int unsigned len;
    len = (spf_q < wme_pkg::COLUMNS) ? wme_pkg::COLUMNS : int'(spf_q);
    return ((c + 1) * len) / wme_pkg::COLUMNS;
  endfunction

  // Screen row of a sample. Both divisions truncate toward zero; the clamp only
  // bites when the rows are inverted, where raising to the top wins.
  function automatic logic [wme_pkg::ROW_W-1:0] screen_row(
      input logic signed [wme_pkg::SAMPLE_W-1:0] s);
    int ctr;
    int half;
    int y;
    ctr  = (int'(top_q) + int'(bot_q)) / 2;
    half = (int'(bot_q) - int'(top_q)) / 2;
    y    = ctr - (int'(s) * half) / 32768;
    if (y < int'(top_q)) begin
      y = int'(top_q);
    end else if (y > int'(bot_q)) begin
      y = int'(bot_q);
    end
    return y[wme_pkg::ROW_W-1:0];
  endfunction

  // Folds one sample into the column envelope. Returns 1 with the finished
  // column when the sample closes it.
  function automatic bit envelope_step(input logic signed [wme_pkg::SAMPLE_W-1:0] s,
                                       output col_env_t env);
    bit last_col;
    env = NO_ENV;
    if (pos_q == 16'd0) begin
      col_q   = 8'd0;
      bound_q = 16'(col_end(0));
    end
    if (!open_q) begin
      lo_q   = s;
      hi_q   = s;
      open_q = 1'b1;
    end else begin
      if (s < lo_q) lo_q = s;
      if (s > hi_q) hi_q = s;
    end
    pos_q = pos_q + 16'd1;
    if (pos_q < bound_q) return 1'b0;

    last_col       = (int'(col_q) + 1 >= int'(wme_pkg::COLUMNS));
    env.column     = col_q;
    env.peak       = screen_row(hi_q);
    env.trough     = screen_row(lo_q);
    env.frame_end  = last_col;
    open_q         = 1'b0;
    if (last_col) begin
      pos_q = 16'd0;
      col_q = 8'd0;
    end else begin
      col_q   = col_q + 8'd1;
      bound_q = 16'(col_end(col_q));
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t: error: %s", $time, msg);
    mismatch_count++;
  endtask

  // Holds the sender off until every owed column has been taken.
  task automatic drain_results();
    smp_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_env.size() != 0);
  endtask

  // Register writes happen only with the block empty, after the pipeline hold-off.
  task automatic write_reg(input wme_pkg::wme_reg_e sel,
                           input logic [wme_pkg::CFG_DATA_W-1:0] val);
    drain_results();
    repeat (HOLD_OFF) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      wme_pkg::REG_SPF:    spf_q = val;
      wme_pkg::REG_TOP:    top_q = val[wme_pkg::ROW_W-1:0];
      wme_pkg::REG_BOTTOM: bot_q = val[wme_pkg::ROW_W-1:0];
      default: ;
    endcase
  endtask

  // Drives one sample beat with random leading gaps and records what it owes.
  // Called at a rising edge; returns at the edge where the beat was taken.
  task automatic send_sample(input logic [15:0] s, input bit typed, input col_env_t want);
    col_env_t env;
    bit       closes;
    while ($urandom_range(99) < send_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    do @(posedge clk_i); while (!smp_if.ready);
    closes = envelope_step($signed(s), env);
    if (typed) begin
      pending_env.push_back(want);
    end else if (closes) begin
      pending_env.push_back(env);
    end
  endtask

  // Full scale, values near zero, or any 16-bit pattern.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      1: return 16'($urandom_range(512)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver side: ready stalls at the phase's rate.
  always @(posedge clk_i) begin
    env_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every result beat is matched against the oldest owed column.
  always @(posedge clk_i) begin
    col_env_t got;
    col_env_t exp_env;
    if (rst_ni && env_if.valid && env_if.ready) begin
      got = '{env_if.column, env_if.peak_row, env_if.trough_row, env_if.frame_end};
      if (pending_env.size() == 0) begin
        flag_mismatch($sformatf("unexpected result beat, column %0d", got.column));
      end else begin
        exp_env = pending_env.pop_front();
        if (got.column !== exp_env.column)
          flag_mismatch($sformatf("column %0d, expected %0d", got.column, exp_env.column));
        if (got.peak !== exp_env.peak)
          flag_mismatch($sformatf("column %0d peak_row %0d, expected %0d",
                                  exp_env.column, got.peak, exp_env.peak));
        if (got.trough !== exp_env.trough)
          flag_mismatch($sformatf("column %0d trough_row %0d, expected %0d",
                                  exp_env.column, got.trough, exp_env.trough));
        if (got.frame_end !== exp_env.frame_end)
          flag_mismatch($sformatf("column %0d frame_end %0b, expected %0b",
                                  exp_env.column, got.frame_end, exp_env.frame_end));
      end
    end
  end

  // Watchdog for a block that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count, pending_env.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = wme_pkg::REG_SPF;
    cfg_wdata_i    = '0;
    smp_if.valid   = 1'b0;
    smp_if.sample  = '0;
    send_idle_pct  = 20;
    recv_idle_pct  = 77;

    // Shadow state after reset.
    spf_q   = wme_pkg::SPF_RESET;
    top_q   = wme_pkg::TOP_RESET;
    bot_q   = wme_pkg::BOTTOM_RESET;
    pos_q   = '0;
    col_q   = '0;
    bound_q = '0;
    lo_q    = '0;
    hi_q    = '0;
    open_q  = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed script.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_WRITE) begin
        write_reg(SCRIPT[i].reg_sel, SCRIPT[i].value);
      end else begin
        send_sample(SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].want);
      end
    end

    // Random phases. Now and then the sender waits for all owed columns.
    for (int p = 0; p < PHASE_CNT; p++) begin
      send_idle_pct = PHASES[p].send_pct;
      recv_idle_pct = PHASES[p].recv_pct;
      write_reg(wme_pkg::REG_SPF, PHASES[p].spf);
      write_reg(wme_pkg::REG_TOP, wme_pkg::CFG_DATA_W'(PHASES[p].top));
      write_reg(wme_pkg::REG_BOTTOM, wme_pkg::CFG_DATA_W'(PHASES[p].bottom));
      for (int n = 0; n < int'(PHASES[p].beats); n++) begin
        if ($urandom_range(49) == 0) drain_results();
        send_sample(pick_sample(), 1'b0, NO_ENV);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
